>>> hw/rtl/acs_pkg.sv
// Shared types, constants and shaping functions for the Arabic contextual shaper.
// Holds the presentation-form table, the joining sets and the lam-alef ligature codes.
// Has no dependencies on other files.
package acs_pkg;

   typedef struct packed {
      logic [15:0] code_point;
      logic        end_of_string;
   } req_type;

   typedef struct packed {
      logic [15:0] shaped_code;
      logic        last_out;
   } rsp_type;

   localparam logic [15:0] ARABIC_FIRST = 16'h0621;
   localparam logic [15:0] ARABIC_LAST  = 16'h064A;
   localparam logic [15:0] LAM          = 16'h0644;
   localparam logic [15:0] ALEF_MADDA   = 16'h0622;
   localparam logic [15:0] ALEF_HAMZA_A = 16'h0623;
   localparam logic [15:0] ALEF_HAMZA_B = 16'h0625;
   localparam logic [15:0] ALEF_PLAIN   = 16'h0627;

   // Isolated lam-alef ligature for each alef variant; the final form is one above.
   localparam logic [15:0] LIG_BASE [4] = '{16'hFEF5, 16'hFEF7, 16'hFEF9, 16'hFEFB};

   // Form table columns.
   localparam logic [1:0] COL_PREV = 2'd0;
   localparam logic [1:0] COL_NEXT = 2'd1;
   localparam logic [1:0] COL_BOTH = 2'd2;
   localparam logic [1:0] COL_NONE = 2'd3;

   localparam logic [15:0] FORM_TABLE [42][4] = '{
      '{16'hfe80,16'hfe80,16'hfe80,16'hfe80}, '{16'hfe82,16'hfe81,16'hfe82,16'hfe81},
      '{16'hfe84,16'hfe83,16'hfe84,16'hfe83}, '{16'hfe86,16'hfe85,16'hfe86,16'hfe85},
      '{16'hfe88,16'hfe87,16'hfe88,16'hfe87}, '{16'hfe8a,16'hfe8b,16'hfe8c,16'hfe89},
      '{16'hfe8e,16'hfe8d,16'hfe8e,16'hfe8d}, '{16'hfe90,16'hfe91,16'hfe92,16'hfe8f},
      '{16'hfe94,16'hfe93,16'hfe94,16'hfe93}, '{16'hfe96,16'hfe97,16'hfe98,16'hfe95},
      '{16'hfe9a,16'hfe9b,16'hfe9c,16'hfe99}, '{16'hfe9e,16'hfe9f,16'hfea0,16'hfe9d},
      '{16'hfea2,16'hfea3,16'hfea4,16'hfea1}, '{16'hfea6,16'hfea7,16'hfea8,16'hfea5},
      '{16'hfeaa,16'hfea9,16'hfeaa,16'hfea9}, '{16'hfeac,16'hfeab,16'hfeac,16'hfeab},
      '{16'hfeae,16'hfead,16'hfeae,16'hfead}, '{16'hfeb0,16'hfeaf,16'hfeb0,16'hfeaf},
      '{16'hfeb2,16'hfeb3,16'hfeb4,16'hfeb1}, '{16'hfeb6,16'hfeb7,16'hfeb8,16'hfeb5},
      '{16'hfeba,16'hfebb,16'hfebc,16'hfeb9}, '{16'hfebe,16'hfebf,16'hfec0,16'hfebd},
      '{16'hfec2,16'hfec3,16'hfec4,16'hfec1}, '{16'hfec6,16'hfec7,16'hfec8,16'hfec5},
      '{16'hfeca,16'hfecb,16'hfecc,16'hfec9}, '{16'hfece,16'hfecf,16'hfed0,16'hfecd},
      '{16'h063b,16'h063b,16'h063b,16'h063b}, '{16'h063c,16'h063c,16'h063c,16'h063c},
      '{16'h063d,16'h063d,16'h063d,16'h063d}, '{16'h063e,16'h063e,16'h063e,16'h063e},
      '{16'h063f,16'h063f,16'h063f,16'h063f}, '{16'h0640,16'h0640,16'h0640,16'h0640},
      '{16'hfed2,16'hfed3,16'hfed4,16'hfed1}, '{16'hfed6,16'hfed7,16'hfed8,16'hfed5},
      '{16'hfeda,16'hfedb,16'hfedc,16'hfed9}, '{16'hfede,16'hfedf,16'hfee0,16'hfedd},
      '{16'hfee2,16'hfee3,16'hfee4,16'hfee1}, '{16'hfee6,16'hfee7,16'hfee8,16'hfee5},
      '{16'hfeea,16'hfeeb,16'hfeec,16'hfee9}, '{16'hfeee,16'hfeed,16'hfeee,16'hfeed},
      '{16'hfef0,16'hfeef,16'hfef0,16'hfeef}, '{16'hfef2,16'hfef3,16'hfef4,16'hfef1}
   };

   // Characters that connect to the character after them.
   function automatic logic joins_forward(input logic [15:0] c);
      case (c)
         16'h062c, 16'h062d, 16'h062e, 16'h0647, 16'h0639, 16'h063a, 16'h0641, 16'h0642,
         16'h062b, 16'h0635, 16'h0636, 16'h0637, 16'h0643, 16'h0645, 16'h0646, 16'h062a,
         16'h0644, 16'h0628, 16'h064a, 16'h0633, 16'h0634, 16'h0638, 16'h0626:
            return 1'b1;
         default:
            return 1'b0;
      endcase
   endfunction

   // Characters that connect to the character before them.
   function automatic logic joins_back(input logic [15:0] c);
      case (c)
         16'h062c, 16'h062d, 16'h062e, 16'h0647, 16'h0639, 16'h063a, 16'h0641, 16'h0642,
         16'h062b, 16'h0635, 16'h0636, 16'h0637, 16'h0643, 16'h0645, 16'h0646, 16'h062a,
         16'h0644, 16'h0628, 16'h064a, 16'h0633, 16'h0634, 16'h0638, 16'h0626,
         16'h0627, 16'h0623, 16'h0625, 16'h0622, 16'h062f, 16'h0630, 16'h0631, 16'h0632,
         16'h0648, 16'h0624, 16'h0629, 16'h0649:
            return 1'b1;
         default:
            return 1'b0;
      endcase
   endfunction

   function automatic logic is_alef(input logic [15:0] c);
      return (c == ALEF_MADDA) || (c == ALEF_HAMZA_A) || (c == ALEF_HAMZA_B) ||
             (c == ALEF_PLAIN);
   endfunction

   function automatic logic [1:0] alef_sel(input logic [15:0] c);
      case (c)
         ALEF_MADDA:   return 2'd0;
         ALEF_HAMZA_A: return 2'd1;
         ALEF_HAMZA_B: return 2'd2;
         default:      return 2'd3;
      endcase
   endfunction

   // Presentation form of cur given its neighbors; non-Arabic codes pass through.
   function automatic logic [15:0] shape_char(input logic [15:0] prev,
                                             input logic [15:0] cur,
                                             input logic [15:0] next);
      logic        f;
      logic        b;
      logic [1:0]  col;
      logic [15:0] off;
      f   = joins_forward(prev);
      b   = joins_back(next);
      off = cur - ARABIC_FIRST;
      if (f && b) begin
         col = COL_BOTH;
      end else if (f) begin
         col = COL_PREV;
      end else if (b) begin
         col = COL_NEXT;
      end else begin
         col = COL_NONE;
      end
      if ((cur < ARABIC_FIRST) || (cur > ARABIC_LAST)) begin
         return cur;
      end
      return FORM_TABLE[off[5:0]][col];
   endfunction

   function automatic logic [15:0] ligature_code(input logic [15:0] prev,
                                                input logic [15:0] alef);
      return LIG_BASE[alef_sel(alef)] + {15'd0, joins_forward(prev)};
   endfunction

endpackage

>>> hw/rtl/arabic_contextual_shaper.sv
// Top level of the Arabic contextual shaper: context registers, shaping logic
// and a small result queue. Depends on acs_pkg for types, tables and functions.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-------------------------------
//  req_    | in        | req_valid / req_stall | req_data: code_point, eos flag
//  rsp_    | out       | rsp_valid / rsp_stall | rsp_data: shaped_code, last_out
//
// One code point is taken per clock while req_stall is low. A transfer in produces
// zero, one or two results, which are registered into a four-entry result queue;
// the queue drains one result per clock while rsp_stall is low. No run of code points
// yields more results than it holds, so with the receiver ready the queue never holds
// more than two and the input never stalls. req_stall rises when fewer than two queue
// entries are free, which only happens while rsp_stall holds results back.
// Reset is synchronous and active high; it clears the context and empties the
// queue. Queue data is not reset.
module arabic_contextual_shaper
   import acs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int QDEPTH  = 4;
   localparam int PTR_W   = $clog2(QDEPTH);
   localparam int CNT_W   = $clog2(QDEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QDEPTH - 2);

   // Context: the held character, its valid flag and the character before it.
   logic [15:0] pending_code_ff, pending_code_in;
   logic        pending_valid_ff, pending_valid_in;
   logic [15:0] before_code_ff, before_code_in;

   // Result queue.
   rsp_type          queue_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   logic        req_take;
   logic        rsp_take;
   logic [1:0]  num_res;
   logic [1:0]  push;
   rsp_type     res0;
   rsp_type     res1;
   logic [15:0] x;
   logic        eos;

   assign x   = req_data.code_point;
   assign eos = req_data.end_of_string;

   // Two slots must be free so that a string end can always write both results.
   assign req_stall = (count_ff > ROOM_LIMIT);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   // Shaping of one incoming code point against the held context.
   always_comb begin
      pending_code_in  = pending_code_ff;
      pending_valid_in = pending_valid_ff;
      before_code_in   = before_code_ff;
      num_res          = 2'd0;
      res0             = '{shaped_code: shape_char(before_code_ff, pending_code_ff, x),
                           last_out: 1'b0};
      res1             = '{shaped_code: shape_char(pending_code_ff, x, 16'd0),
                           last_out: 1'b1};
      if (!pending_valid_ff) begin
         if (eos) begin
            // A lone character has no successor and is shaped at once.
            res0           = '{shaped_code: shape_char(before_code_ff, x, 16'd0),
                               last_out: 1'b1};
            num_res        = 2'd1;
            before_code_in = 16'd0;
         end else begin
            pending_code_in  = x;
            pending_valid_in = 1'b1;
         end
      end else if ((pending_code_ff == LAM) && is_alef(x)) begin
         // Lam then alef fuse into one ligature; the alef becomes the predecessor.
         res0             = '{shaped_code: ligature_code(before_code_ff, x), last_out: eos};
         num_res          = 2'd1;
         pending_valid_in = 1'b0;
         pending_code_in  = 16'd0;
         before_code_in   = eos ? 16'd0 : x;
      end else if (eos) begin
         // The held character and the last one both leave.
         num_res          = 2'd2;
         pending_valid_in = 1'b0;
         pending_code_in  = 16'd0;
         before_code_in   = 16'd0;
      end else begin
         num_res         = 2'd1;
         before_code_in  = pending_code_ff;
         pending_code_in = x;
      end
   end

   assign push = req_take ? num_res : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_code_ff  <= 16'd0;
         pending_valid_ff <= 1'b0;
         before_code_ff   <= 16'd0;
      end else if (req_take) begin
         pending_code_ff  <= pending_code_in;
         pending_valid_ff <= pending_valid_in;
         before_code_ff   <= before_code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(rsp_take);
         count_ff  <= count_ff + CNT_W'(push) - CNT_W'(rsp_take);
      end
   end

   always_ff @(posedge clock) begin
      if (push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push == 2'd2) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

   // The queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QDEPTH))
      else $error("result queue overflow");

   // A string end always leaves the context empty.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && eos) |=> (!pending_valid_ff && (before_code_ff == 16'd0)))
      else $error("context not cleared at end of string");

   // An empty context holds no character.
   assert property (@(posedge clock) disable iff (reset)
      !pending_valid_ff |-> (pending_code_ff == 16'd0))
      else $error("stale pending character");

   // An accepted item that yields results shows a queued result next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (push != 2'd0) |=> rsp_valid)
      else $error("result lost");

endmodule
